FILE: hdl/cls_pkg.sv
`timescale 1ns / 1ps

package cls_pkg;

    // Field widths of the words on the two channels.
    localparam int ACTION_W = 2;
    localparam int PIXEL_W  = 8;
    localparam int PAIR_W   = 5;
    localparam int ROW_W    = 6;
    localparam int COL_W    = 6;
    localparam int POS_W    = 7;
    localparam int LINE_W   = 9;

    // Default geometry of the capture.
    localparam int DEF_ROWS = 40;
    localparam int DEF_COLS = 90;

    // Threshold after reset.
    localparam logic [PIXEL_W-1:0] THRESHOLD_RESET = 8'h60;

    // Event codes carried in the action field.
    localparam logic [ACTION_W-1:0] ACT_FRAME = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_LINE  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_PIXEL = 2'd2;

    localparam logic [LINE_W-1:0] LINE_MAX = 9'd511;

    // Camera line numbers at which successive rows are captured.
    localparam int ROM_DEPTH = 61;
    localparam logic [LINE_W-1:0] LINE_ROM [ROM_DEPTH] = '{
        9'd16,  9'd29,  9'd41,  9'd52,  9'd62,  9'd71,  9'd79,  9'd86,  9'd92,  9'd98,
        9'd103, 9'd108, 9'd112, 9'd116, 9'd120, 9'd124, 9'd128, 9'd132, 9'd135, 9'd138,
        9'd141, 9'd144, 9'd147, 9'd150, 9'd153, 9'd156, 9'd159, 9'd162, 9'd165, 9'd168,
        9'd170, 9'd172, 9'd174, 9'd176, 9'd178, 9'd180, 9'd182, 9'd184, 9'd186, 9'd188,
        9'd190, 9'd192, 9'd194, 9'd196, 9'd198, 9'd200, 9'd202, 9'd204, 9'd206, 9'd208,
        9'd210, 9'd211, 9'd212, 9'd242, 9'd243, 9'd245, 9'd246, 9'd247, 9'd248, 9'd249,
        9'd250
    };

    // What the line tracker tells the pair packer about the current word.
    typedef struct packed {
        logic             take;    // pixel belongs to a captured row
        logic             hold;    // first pixel of a pair, keep its bit
        logic             odd;     // second pixel of a pair
        logic             last;    // final pair of the final row
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } t_pix_ctl;

endpackage

FILE: hdl/cls_in_if.sv
`timescale 1ns / 1ps

interface cls_in_if;
    logic                      valid;
    logic                      ready;
    logic [cls_pkg::ACTION_W-1:0] action;
    logic [cls_pkg::PIXEL_W-1:0]  pixel;

    modport source (output valid, output action, output pixel, input ready);
    modport sink   (input valid, input action, input pixel, output ready);
endinterface

FILE: hdl/cls_out_if.sv
`timescale 1ns / 1ps

interface cls_out_if;
    logic                       valid;
    logic                       ready;
    logic [cls_pkg::PAIR_W-1:0] packed_pair;
    logic [cls_pkg::ROW_W-1:0]  row;
    logic [cls_pkg::COL_W-1:0]  pair_column;
    logic                       last_of_frame;

    modport source (output valid, output packed_pair, output row, output pair_column,
                    output last_of_frame, input ready);
    modport sink   (input valid, input packed_pair, input row, input pair_column,
                    input last_of_frame, output ready);
endinterface

FILE: hdl/cls_line_track.sv
`timescale 1ns / 1ps

module cls_line_track #(
    parameter int ROWS = cls_pkg::DEF_ROWS,
    parameter int COLS = cls_pkg::DEF_COLS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic [cls_pkg::ACTION_W-1:0]  i_action,
    output cls_pkg::t_pix_ctl             o_ctl
);
    import cls_pkg::*;

    logic [LINE_W-1:0] r_line, n_line;
    logic [ROW_W-1:0]  r_row, n_row;
    logic              r_active, n_active;
    logic [POS_W-1:0]  r_pos, n_pos;

    logic [ROW_W-1:0]  w_row_open;
    logic              w_select;
    logic              w_final;

    // Row index seen by a line start after any open row has been closed.
    assign w_row_open = r_active ? r_row + 1'b1 : r_row;
    assign w_select   = (w_row_open < ROW_W'(ROWS)) && (w_row_open < ROW_W'(ROM_DEPTH)) &&
                        (r_line == LINE_ROM[w_row_open]);
    assign w_final    = (r_pos == POS_W'(COLS - 1));

    always_comb begin
        o_ctl.take = (i_action == ACT_PIXEL) && r_active && (r_pos < POS_W'(COLS));
        o_ctl.odd  = r_pos[0];
        o_ctl.hold = !r_pos[0] && !w_final;
        o_ctl.last = w_final && (r_row == ROW_W'(ROWS - 1));
        o_ctl.row  = r_row;
        o_ctl.col  = r_pos[POS_W-1:1];
    end

    always_comb begin
        n_line   = r_line;
        n_row    = r_row;
        n_active = r_active;
        n_pos    = r_pos;
        unique case (i_action)
            ACT_FRAME: begin
                n_line   = '0;
                n_row    = '0;
                n_active = 1'b0;
                n_pos    = '0;
            end
            ACT_LINE: begin
                n_row    = w_row_open;
                n_active = w_select;
                n_pos    = '0;
                if (r_line < LINE_MAX) begin
                    n_line = r_line + 1'b1;
                end
            end
            ACT_PIXEL: begin
                if (o_ctl.take) begin
                    if (w_final) begin
                        n_active = 1'b0;
                        n_pos    = '0;
                        n_row    = r_row + 1'b1;
                    end else begin
                        n_pos = r_pos + 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line   <= '0;
            r_row    <= '0;
            r_active <= 1'b0;
            r_pos    <= '0;
        end else if (i_step) begin
            r_line   <= n_line;
            r_row    <= n_row;
            r_active <= n_active;
            r_pos    <= n_pos;
        end
    end

    a_pos_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos < POS_W'(COLS))
        else $error("pixel position ran past the row length");

    a_idle_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_active |-> r_pos == '0)
        else $error("pixel position not cleared outside a captured row");

    a_active_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> r_row < ROW_W'(ROWS))
        else $error("captured row index beyond the row count");

endmodule

FILE: hdl/cls_pair_pack.sv
`timescale 1ns / 1ps

module cls_pair_pack (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [cls_pkg::PIXEL_W-1:0]   i_cfg_data,
    input  logic                          i_step,
    input  logic [cls_pkg::PIXEL_W-1:0]   i_pixel,
    input  cls_pkg::t_pix_ctl             i_ctl,
    output logic                          o_free,
    cls_out_if.source                     o_out
);
    import cls_pkg::*;

    logic [PIXEL_W-1:0] r_threshold;
    logic               r_held;
    logic               r_valid;
    logic [PAIR_W-1:0]  r_pair;
    logic [ROW_W-1:0]   r_row;
    logic [COL_W-1:0]   r_col;
    logic               r_last;

    logic w_dark;
    logic w_first;
    logic w_second;
    logic w_emit;

    assign w_dark   = i_pixel < r_threshold;
    assign w_first  = i_ctl.odd ? r_held : w_dark;
    assign w_second = i_ctl.odd ? w_dark : 1'b0;
    assign w_emit   = i_step && i_ctl.take && !i_ctl.hold;

    // The result register can take a new word when empty or being drained.
    assign o_free = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RESET;
        end else if (i_cfg_we) begin
            r_threshold <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= 1'b0;
        end else if (i_step && i_ctl.take) begin
            r_held <= i_ctl.hold ? w_dark : 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_emit) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_pair <= {w_first, 3'b000, w_second};
            r_row  <= i_ctl.row;
            r_col  <= i_ctl.col;
            r_last <= i_ctl.last;
        end
    end

    assign o_out.valid         = r_valid;
    assign o_out.packed_pair   = r_pair;
    assign o_out.row           = r_row;
    assign o_out.pair_column   = r_col;
    assign o_out.last_of_frame = r_last;

    a_emit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> r_valid)
        else $error("emitted pair did not reach the result register");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step |-> o_free)
        else $error("word processed while the result register was blocked");

endmodule

FILE: hdl/camera_line_select_threshold_pack.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake              Payload
// i_in      in   valid / ready          action[1:0], pixel[7:0]
// o_out     out  valid / ready          packed_pair[4:0], row[5:0], pair_column[5:0], last_of_frame
// cfg       in   i_cfg_we (write only)  i_cfg_data[7:0] = dark threshold
//
// Each word passes one input register and one result register. A pair word reaches o_out
// once its input word has been processed out of the input register, and not before.
// One word is taken every cycle when o_out is not stalled, since the result register can
// load while its current word is being taken. Reset is synchronous and active low; it clears
// the line and row counters and sets the threshold to 96. A stall on o_out fills the result
// register and then the input register, after which i_in.ready drops.

module camera_line_select_threshold_pack #(
    parameter int ROWS = cls_pkg::DEF_ROWS,
    parameter int COLS = cls_pkg::DEF_COLS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [cls_pkg::PIXEL_W-1:0] i_cfg_data,
    cls_in_if.sink                      i_in,
    cls_out_if.source                   o_out
);
    import cls_pkg::*;

    // Input register holding one camera word.
    logic                r_in_valid;
    logic [ACTION_W-1:0] r_action;
    logic [PIXEL_W-1:0]  r_pixel;

    // A word in the input register is processed when the result side has room.
    logic     w_out_free;
    logic     w_step;
    t_pix_ctl w_ctl;

    assign w_step     = r_in_valid && w_out_free;
    assign i_in.ready = !r_in_valid || w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_action <= i_in.action;
            r_pixel  <= i_in.pixel;
        end
    end

    // Frame and line counting, row selection and pixel position.
    cls_line_track #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_track (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_action (r_action),
        .o_ctl    (w_ctl)
    );

    // Thresholding, pair packing and the result register.
    cls_pair_pack u_pack (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_step     (w_step),
        .i_pixel    (r_pixel),
        .i_ctl      (w_ctl),
        .o_free     (w_out_free),
        .o_out      (o_out)
    );

    // A stalled word must stay in the input register until processed.
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_step |=> r_in_valid)
        else $error("input word dropped while stalled");

endmodule

FILE: bench/camera_line_select_threshold_pack_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the camera line selector. A scoreboard class keeps its own
// copy of the line counter, row index and pair packer, and predicts the pair words
// for every accepted input word. Every word that leaves the block is compared with
// the oldest prediction. Stimulus is a short hand-written opening, followed by whole
// camera frames with random pixel content: full frames, broken frames and one very
// long frame. Both channels idle at random. The receiver also holds off once for a
// long stretch, and the sender drains all results before each threshold change.
module camera_line_select_threshold_pack_tb;
    import cls_pkg::*;

    // The block is tested at its default geometry.
    localparam int N_ROWS = DEF_ROWS;
    localparam int N_COLS = DEF_COLS;

    // The action field has one code that the block does not use.
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    localparam int TARGET_WORDS  = 1700;
    localparam int HOLD_CYCLES   = 150;
    // The pipeline is two registers deep, so a few cycles cover words that give no pair.
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 200000;

    typedef struct packed {
        logic [PAIR_W-1:0] packed_pair;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  pair_column;
        logic              last_of_frame;
    } t_pair_word;

    // The class tracks the block's state, holds the pairs that are still due,
    // and counts mismatches.
    class pair_scoreboard;
        logic [PIXEL_W-1:0] threshold;
        logic [LINE_W-1:0]  line_count;
        logic [ROW_W-1:0]   row_idx;
        bit                 row_open;
        logic [POS_W-1:0]   pix_pos;
        bit                 held_dark;
        t_pair_word         expected_pairs[$];
        int                 error_count;

        function new();
            threshold   = THRESHOLD_RESET;
            line_count  = '0;
            row_idx     = '0;
            row_open    = 1'b0;
            pix_pos     = '0;
            held_dark   = 1'b0;
            error_count = 0;
        endfunction

        function void close_row();
            row_open  = 1'b0;
            pix_pos   = '0;
            held_dark = 1'b0;
            row_idx   = row_idx + 1'b1;
        endfunction

        // Advances the state by one accepted input word. If the word completes a
        // pair, the pair is queued.
        function void note_word(logic [ACTION_W-1:0] act, logic [PIXEL_W-1:0] pix);
            t_pair_word w;
            bit         dark;
            bit         last_pix;
            if (act == ACT_FRAME) begin
                line_count = '0;
                row_idx    = '0;
                row_open   = 1'b0;
                pix_pos    = '0;
                held_dark  = 1'b0;
            end else if (act == ACT_LINE) begin
                if (row_open)
                    close_row();
                if (row_idx < N_ROWS && row_idx < ROM_DEPTH &&
                    line_count == LINE_ROM[row_idx]) begin
                    row_open  = 1'b1;
                    pix_pos   = '0;
                    held_dark = 1'b0;
                end
                if (line_count < LINE_MAX)
                    line_count = line_count + 1'b1;
            end else if (act == ACT_PIXEL && row_open && pix_pos < N_COLS) begin
                dark     = pix < threshold;
                last_pix = (int'(pix_pos) + 1) == N_COLS;
                if (!pix_pos[0] && !last_pix) begin
                    held_dark = dark;
                    pix_pos   = pix_pos + 1'b1;
                end else begin
                    // When the row has an odd width, its lone last pixel is paired with a zero.
                    if (pix_pos[0])
                        w.packed_pair = {held_dark, 3'b000, dark};
                    else
                        w.packed_pair = {dark, 4'b0000};
                    w.row           = row_idx;
                    w.pair_column   = pix_pos[POS_W-1:1];
                    w.last_of_frame = last_pix && row_idx == N_ROWS - 1;
                    expected_pairs.push_back(w);
                    held_dark = 1'b0;
                    if (last_pix)
                        close_row();
                    else
                        pix_pos = pix_pos + 1'b1;
                end
            end
        endfunction

        task report(string msg);
            $display("%0t ns: mismatch: %s", $realtime, msg);
            error_count++;
        endtask

        task check_pair(t_pair_word got);
            t_pair_word exp_w;
            if (expected_pairs.size() == 0) begin
                report($sformatf("pair word %h arrived with none expected", got));
            end else begin
                exp_w = expected_pairs.pop_front();
                if (got.packed_pair != exp_w.packed_pair)
                    report($sformatf("packed_pair %0d, expected %0d",
                                     got.packed_pair, exp_w.packed_pair));
                if (got.row != exp_w.row)
                    report($sformatf("row %0d, expected %0d", got.row, exp_w.row));
                if (got.pair_column != exp_w.pair_column)
                    report($sformatf("pair_column %0d, expected %0d",
                                     got.pair_column, exp_w.pair_column));
                if (got.last_of_frame != exp_w.last_of_frame)
                    report($sformatf("last_of_frame %0d, expected %0d",
                                     got.last_of_frame, exp_w.last_of_frame));
            end
        endtask
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [PIXEL_W-1:0] i_cfg_data;

    cls_in_if  in_if();
    cls_out_if out_if();

    pair_scoreboard sb = new();

    // Random idling on both channels can be switched off for a stretch.
    bit idle_enable  = 1'b1;
    // The main process bumps hold_tag to ask the receiver for one long hold-off.
    int hold_tag     = 0;
    bit hold_on_last = 1'b0;
    int words_sent   = 0;
    int cycle_count  = 0;

    camera_line_select_threshold_pack #(
        .ROWS(N_ROWS),
        .COLS(N_COLS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver. Ready changes on the falling edge. When the main process requests a
    // hold-off, this process keeps ready low until a countdown from HOLD_CYCLES ends. Meanwhile the
    // sender keeps offering words, so the block fills up and stalls its input.
    int hold_seen = 0;
    int hold_left = 0;
    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_tag != hold_seen) begin
                hold_seen = hold_tag;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= !(idle_enable && $urandom_range(99) < 7);
            end
        end
    end

    // Both handshakes are sampled on the rising edge. The output is checked before
    // the input word is noted. This order makes no difference, because a pair never
    // leaves in the same cycle as the word that causes it.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready)
                sb.check_pair({out_if.packed_pair, out_if.row, out_if.pair_column,
                               out_if.last_of_frame});
            if (in_if.valid && in_if.ready)
                sb.note_word(in_if.action, in_if.pixel);
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // Offers one word and returns on the falling edge after it is accepted. Valid
    // stays high into the next call, unless that call starts with a random gap.
    task automatic send_word(input logic [ACTION_W-1:0] act, input logic [PIXEL_W-1:0] pix);
        while (idle_enable && $urandom_range(99) < 7) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid  <= 1'b1;
        in_if.action <= act;
        in_if.pixel  <= pix;
        @(posedge i_clk);
        while (!in_if.ready)
            @(posedge i_clk);
        @(negedge i_clk);
        if (act != ACT_UNUSED)
            words_sent++;
    endtask

    // Stops sending and waits until every expected pair has arrived. It then waits
    // a few more cycles for words that give no pair to leave the pipeline.
    task automatic wait_idle();
        in_if.valid <= 1'b0;
        do
            @(negedge i_clk);
        while (sb.expected_pairs.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // The threshold is only written while the block is idle.
    task automatic set_threshold(input logic [PIXEL_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.threshold = value;
    endtask

    // Sends pixels. About half fall within a few counts of the threshold, so both
    // sides of the compare are tested. Now and then a word with the unused code
    // is mixed in. The block must ignore it and keep the row open.
    task automatic send_row(input int n_pix);
        int lo;
        int hi;
        logic [PIXEL_W-1:0] pix;
        for (int i = 0; i < n_pix; i++) begin
            if ($urandom_range(19) == 0)
                send_word(ACT_UNUSED, PIXEL_W'($urandom_range(255)));
            if ($urandom_range(1)) begin
                pix = PIXEL_W'($urandom_range(255));
            end else begin
                lo  = (sb.threshold < 2) ? 0 : int'(sb.threshold) - 2;
                hi  = (lo + 3 > 255) ? 255 : lo + 3;
                pix = PIXEL_W'($urandom_range(hi, lo));
            end
            send_word(ACT_PIXEL, pix);
        end
    endtask

    // One frame: a frame start, then n_lines line starts. A captured line gets a
    // short row, or a full row now and then. Some full rows run a few pixels past
    // the row width. When full_last is set, the last captured row is full, so the
    // frame ends with last_of_frame. Some lines that are not captured carry stray
    // pixels. If n_lines ends inside a captured row, the next frame start cuts it off.
    task automatic run_frame(input int n_lines, input bit full_last, input int short_max,
                             input int full_pct);
        int rom_pos;
        int n_pix;
        rom_pos = 0;
        send_word(ACT_FRAME, PIXEL_W'($urandom_range(255)));
        for (int ln = 0; ln < n_lines; ln++) begin
            send_word(ACT_LINE, PIXEL_W'($urandom_range(255)));
            if (rom_pos < N_ROWS && ln == LINE_ROM[rom_pos]) begin
                rom_pos++;
                if (rom_pos == N_ROWS && full_last) begin
                    n_pix = N_COLS + $urandom_range(3);
                    if (hold_on_last) begin
                        hold_on_last = 1'b0;
                        hold_tag++;
                    end
                end else if ($urandom_range(99) < full_pct) begin
                    n_pix = N_COLS + $urandom_range(2);
                end else begin
                    n_pix = $urandom_range(short_max);
                end
                send_row(n_pix);
            end else if ($urandom_range(19) == 0) begin
                send_row($urandom_range(3));
            end
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_data   = '0;
        in_if.valid  = 1'b0;
        in_if.action = ACT_FRAME;
        in_if.pixel  = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Hand-written opening at the reset threshold of 96. First comes a word with
        // the unused code. Then comes a pixel before any row is open. Both must be
        // ignored.
        send_word(ACT_UNUSED, 8'hFF);
        send_word(ACT_PIXEL, 8'h00);
        send_word(ACT_FRAME, 8'h5A);
        // Line numbers 0 to 16. The last of these is captured as row 0.
        for (int i = 0; i < 17; i++)
            send_word(ACT_LINE, PIXEL_W'($urandom_range(255)));
        // Both pixels are dark, at zero and just below the threshold. Then both are
        // light, at the threshold and at full scale.
        send_word(ACT_PIXEL, 8'd0);
        send_word(ACT_PIXEL, 8'd95);
        send_word(ACT_PIXEL, 8'd96);
        send_word(ACT_PIXEL, 8'd255);
        // A single pixel opens a pair. A line start then cuts the row short, so no
        // partial pair may appear.
        send_word(ACT_PIXEL, 8'd0);
        send_word(ACT_LINE, 8'hA5);
        wait_idle();

        // A full frame with the receiver stalled for a long time on the last row.
        set_threshold(8'd200);
        hold_on_last = 1'b1;
        run_frame(LINE_ROM[N_ROWS-1] + 4, 1'b1, 6, 5);
        wait_idle();

        // Next, a long frame with no random idling. The line count runs far past 511,
        // where the line counter saturates.
        idle_enable = 1'b0;
        set_threshold(8'd255);
        run_frame(560, 1'b1, 2, 0);
        wait_idle();
        idle_enable = 1'b1;

        // Random frames follow. Each takes a new threshold, often 0 or 255.
        // Roughly one frame in three is broken off early.
        while (words_sent < TARGET_WORDS) begin
            case ($urandom_range(3))
                0:       set_threshold(8'd0);
                1:       set_threshold(8'd255);
                2:       set_threshold(THRESHOLD_RESET);
                default: set_threshold(PIXEL_W'($urandom_range(255)));
            endcase
            if ($urandom_range(2) == 0)
                run_frame($urandom_range(LINE_ROM[N_ROWS-1], 1), 1'b0, 20, 10);
            else
                run_frame(LINE_ROM[N_ROWS-1] + 1 + $urandom_range(3), 1'b1, 10, 5);
            wait_idle();
        end

        // Extra cycles would catch a pair word the block sends with none expected.
        repeat (20) @(negedge i_clk);
        if (sb.error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

FILE: sim.f
hdl/cls_pkg.sv
hdl/cls_in_if.sv
hdl/cls_out_if.sv
hdl/cls_line_track.sv
hdl/cls_pair_pack.sv
hdl/camera_line_select_threshold_pack.sv
bench/camera_line_select_threshold_pack_tb.sv
